// ----- sv/ant_pkg.sv -----
// shared types and constants for the aging neighbor table
`default_nettype none
package ant_pkg;
  localparam int unsigned ActionWidth = 2;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned TdataInWidth = 264;
  localparam int unsigned TdataOutWidth = 24;
  localparam logic [31:0] TimeoutReset = 32'd5000;

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_MARK   = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_OWN       = 3'd3,
    ST_MARKED    = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_TICK      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_OWN_HIGH = 2'd0,
    REG_OWN_LOW  = 2'd1,
    REG_TIMEOUT  = 2'd2
  } reg_index_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input transaction, clear scan pointers
    logic scan;     // read entry at the read pointer
    logic check;    // evaluate the entry read last cycle
    logic write;    // perform the update/insert write and commit the new valid count
    logic finish;   // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // read pointer reached the valid count or the table depth
    logic hit;        // entry read last cycle matches (search actions)
    logic own;        // update carries the own id
    logic is_tick;
  } stat_t;
endpackage
`default_nettype wire

// ----- sv/ant_datapath.sv -----
// entry memory, scan pointers, compare and result register
`default_nettype none
module ant_datapath
  import ant_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 20
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cmd_t         cmd,
  output stat_t             stat,
  input  wire logic [TdataInWidth-1:0] in_data,
  input  wire logic [63:0]  own_high,
  input  wire logic [63:0]  own_low,
  input  wire logic [31:0]  timeout,
  output logic [TdataOutWidth-1:0] out_data
);
  localparam int unsigned PtrWidth = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxWidth = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // id_high, id_low, speed, lon, lat, last_seen, emergency
  localparam int unsigned EntryWidth = 64 + 64 + 32 + 32 + 32 + 32 + 1;

  logic [EntryWidth-1:0] mem [TABLE_DEPTH];
  logic [EntryWidth-1:0] rd_entry;

  logic [TdataInWidth-1:0] item;
  logic [PtrWidth-1:0] valid_count;
  logic [PtrWidth-1:0] rd_ptr;
  logic [PtrWidth-1:0] chk_ptr;
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] removed;
  logic found;
  logic [PtrWidth-1:0] found_idx;
  logic inserted;

  action_t act;
  logic [31:0] now_ms;
  logic [63:0] s_high;
  logic [63:0] s_low;
  logic [95:0] payload;
  logic id_match;
  logic stale;
  logic [31:0] age;

  assign act     = action_t'(item[1:0]);
  assign now_ms  = item[33:2];
  assign s_high  = item[97:34];
  assign s_low   = item[161:98];
  assign payload = item[257:162];

  assign id_match = (rd_entry[EntryWidth-1 -: 64] == s_high) &&
                    (rd_entry[EntryWidth-65 -: 64] == s_low);
  assign age   = now_ms - rd_entry[32:1];
  assign stale = age > timeout;

  assign stat.scan_done = (rd_ptr == valid_count) ||
                          (rd_ptr == PtrWidth'(TABLE_DEPTH));
  assign stat.hit = cmd.check && id_match && !found;
  assign stat.own = (s_high == own_high) && (s_low == own_low);
  assign stat.is_tick = (act == ACT_TICK);

  // memory read, registered
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_entry <= mem[rd_ptr[IdxWidth-1:0]];
    end
  end

  // memory write: compaction or emergency mark during check, or final update/insert write
  always_ff @(posedge clk) begin
    if (cmd.check && act == ACT_TICK && !stale) begin
      mem[wr_ptr[IdxWidth-1:0]] <= rd_entry;
    end else if (cmd.check && act == ACT_MARK && id_match && !found) begin
      mem[chk_ptr[IdxWidth-1:0]] <= {rd_entry[EntryWidth-1:1], 1'b1};
    end else if (cmd.write && act == ACT_UPDATE && !stat.own) begin
      if (found) begin
        mem[found_idx[IdxWidth-1:0]] <= {s_high, s_low, payload, now_ms,
                                          rd_entry[0]};
      end else if (valid_count != PtrWidth'(TABLE_DEPTH)) begin
        mem[valid_count[IdxWidth-1:0]] <= {s_high, s_low, payload, now_ms, 1'b0};
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // scan pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
      rd_ptr <= '0;
      chk_ptr <= '0;
      wr_ptr <= '0;
      removed <= '0;
      found <= 1'b0;
      found_idx <= '0;
      inserted <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_ptr <= '0;
        wr_ptr <= '0;
        removed <= '0;
        found <= 1'b0;
        found_idx <= '0;
        inserted <= 1'b0;
      end
      if (cmd.scan) begin
        chk_ptr <= rd_ptr;
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (cmd.check) begin
        if (act == ACT_TICK) begin
          if (stale) removed <= removed + 1'b1;
          else wr_ptr <= wr_ptr + 1'b1;
        end else if (id_match && !found) begin
          found <= 1'b1;
          found_idx <= chk_ptr;
        end
      end
      if (cmd.write) begin
        if (act == ACT_TICK) begin
          valid_count <= wr_ptr;
        end else if (act == ACT_UPDATE && !stat.own && !found &&
                     valid_count != PtrWidth'(TABLE_DEPTH)) begin
          valid_count <= valid_count + 1'b1;
          inserted <= 1'b1;
        end
      end
    end
  end

  // result register: status, slot, entry_count, removed_count
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (act)
        ACT_UPDATE: begin
          if (stat.own) begin
            out_data <= {6'b0, 5'd0, CountWidth'(valid_count), 5'd0, ST_OWN};
          end else if (found) begin
            out_data <= {6'b0, 5'd0, CountWidth'(valid_count),
                         CountWidth'(found_idx), ST_REFRESHED};
          end else if (inserted) begin
            // new entry went to the old end of the table
            out_data <= {6'b0, 5'd0, CountWidth'(valid_count),
                         CountWidth'(valid_count - 1'b1), ST_INSERTED};
          end else begin
            out_data <= {6'b0, 5'd0, CountWidth'(valid_count), 5'd0, ST_DROPPED};
          end
        end
        ACT_MARK: begin
          if (found) begin
            out_data <= {6'b0, 5'd0, CountWidth'(valid_count),
                         CountWidth'(found_idx), ST_MARKED};
          end else begin
            out_data <= {6'b0, 5'd0, CountWidth'(valid_count), 5'd0, ST_NOT_FOUND};
          end
        end
        ACT_TICK: begin
          out_data <= {6'b0, CountWidth'(removed), CountWidth'(valid_count),
                       5'd0, ST_TICK};
        end
        default: begin
          out_data <= {6'b0, 5'd0, CountWidth'(valid_count), 5'd0, ST_NOT_FOUND};
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/ant_ctrl.sv -----
// sequencing state machine for search, compaction and result handoff
`default_nettype none
module ant_ctrl
  import ant_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_fire,
  input  wire logic  out_fire,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       in_ready,
  output logic       out_valid
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CHECK = 6'b000100,
    S_WRITE = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_WRITE;
        end else begin
          cmd.scan = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        // first match ends a search; a tick walks the whole table
        state_next = (stat.hit && !stat.is_tick) ? S_WRITE : S_SCAN;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
endmodule
`default_nettype wire

// ----- sv/aging_neighbor_table_top.sv -----
// top level of the aging neighbor table
//
// channel | direction | handshake             | content
// s_axis  | in        | tvalid/tready         | one request transaction
// m_axis  | out       | tvalid/tready         | one result transaction
// cfg     | in        | cfg_valid/cfg_ready   | register index and data
//
// an item scans n entries, each read then checked, then writes and loads
// the result before the handoff, n = entries scanned (up to TABLE_DEPTH);
// a search stops at a match; the entry memory's single read port, one entry
// at a time, sets this pace
// rst is synchronous; the table comes out of reset empty, timeout 5000 ms
// one item is in flight at a time; a stalled result holds s_axis_tready low
`default_nettype none
module aging_neighbor_table_top
  import ant_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 20
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // action, now_ms, sender_id_high, sender_id_low, latitude_bits,
  // longitude_bits, speed_bits, zero pad
  input  wire logic [TdataInWidth-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, slot, entry_count, removed_count, zero pad
  output logic [TdataOutWidth-1:0] m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  logic [63:0] own_high;
  logic [63:0] own_low;
  logic [31:0] timeout;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_high <= '0;
      own_low  <= '0;
      timeout  <= TimeoutReset;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_OWN_HIGH: own_high <= cfg_data;
        REG_OWN_LOW:  own_low  <= cfg_data;
        REG_TIMEOUT:  timeout  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  ant_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (s_axis_tvalid && s_axis_tready),
    .out_fire  (m_axis_tvalid && m_axis_tready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  ant_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .own_high (own_high),
    .own_low  (own_low),
    .timeout  (timeout),
    .out_data (m_axis_tdata)
  );
endmodule
`default_nettype wire

// ----- bench/aging_neighbor_table_top_test.sv -----
// testbench for the aging neighbor table: random and directed requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module aging_neighbor_table_top_test;
  import ant_pkg::*;

  localparam int unsigned Depth = 20;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [31:0] speed;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [63:0] id_low;
    logic [63:0] id_high;
    logic [31:0] now_ms;
    action_t     action;
  } request_t;

  typedef struct packed {
    logic [4:0] removed;
    logic [4:0] count;
    logic [4:0] slot;
    status_t    status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TdataInWidth-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TdataOutWidth-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aging_neighbor_table_top #(.TABLE_DEPTH(Depth)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of the table
  logic [63:0] own_high, own_low;
  logic [31:0] timeout_ms;
  logic [63:0] tbl_high[Depth], tbl_low[Depth];
  logic [31:0] tbl_lat[Depth], tbl_lon[Depth], tbl_speed[Depth], tbl_seen[Depth];
  logic        tbl_emerg[Depth];
  int unsigned tbl_count;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int unsigned error_count = 0;
  int unsigned accepted_count = 0;
  int unsigned queued_count = 0;
  bit calm = 1'b0;
  bit send_done = 1'b0;

  // ids in use, kept few so refresh, mark and drop happen often
  logic [63:0] pool_high[24], pool_low[24];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int find_sender(logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < int'(tbl_count); i++)
      if (tbl_high[i] == hi && tbl_low[i] == lo) return i;
    return -1;
  endfunction

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    int idx;
    int unsigned w;
    logic [31:0] age;
    o = '0;
    o.status = ST_NOT_FOUND;
    case (r.action)
      ACT_UPDATE: begin
        if (r.id_high == own_high && r.id_low == own_low) begin
          o.status = ST_OWN;
        end else begin
          idx = find_sender(r.id_high, r.id_low);
          if (idx >= 0) begin
            o.status = ST_REFRESHED;
            o.slot = idx[4:0];
          end else if (tbl_count < Depth) begin
            idx = tbl_count;
            tbl_high[idx] = r.id_high;
            tbl_low[idx] = r.id_low;
            tbl_emerg[idx] = 1'b0;
            tbl_count++;
            o.status = ST_INSERTED;
            o.slot = idx[4:0];
          end else begin
            o.status = ST_DROPPED;
          end
          if (o.status inside {ST_REFRESHED, ST_INSERTED}) begin
            tbl_lat[idx] = r.lat;
            tbl_lon[idx] = r.lon;
            tbl_speed[idx] = r.speed;
            tbl_seen[idx] = r.now_ms;
          end
        end
      end
      ACT_MARK: begin
        idx = find_sender(r.id_high, r.id_low);
        if (idx >= 0) begin
          tbl_emerg[idx] = 1'b1;
          o.status = ST_MARKED;
          o.slot = idx[4:0];
        end
      end
      ACT_TICK: begin
        // drop aged entries and compact in order
        w = 0;
        for (int i = 0; i < int'(tbl_count); i++) begin
          age = r.now_ms - tbl_seen[i];
          if (age > timeout_ms) begin
            o.removed++;
          end else begin
            tbl_high[w] = tbl_high[i];
            tbl_low[w] = tbl_low[i];
            tbl_lat[w] = tbl_lat[i];
            tbl_lon[w] = tbl_lon[i];
            tbl_speed[w] = tbl_speed[i];
            tbl_seen[w] = tbl_seen[i];
            tbl_emerg[w] = tbl_emerg[i];
            w++;
          end
        end
        tbl_count = w;
        o.status = ST_TICK;
      end
      default: ;
    endcase
    o.count = tbl_count[4:0];
    return o;
  endfunction

  // request driver with random gaps
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) accepted_count++;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        request_t r;
        r = pending_requests.pop_front();
        expected_outcomes.push_back(predict_outcome(r));
        s_axis_tdata <= TdataInWidth'(r);
        s_axis_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random stalls
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        outcome_t got, want;
        got = outcome_t'(m_axis_tdata[17:0]);
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(got.status), 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.slot !== want.slot) report_mismatch("slot", 32'(got.slot), 32'(want.slot));
          if (got.count !== want.count)
            report_mismatch("entry_count", 32'(got.count), 32'(want.count));
          if (got.removed !== want.removed)
            report_mismatch("removed_count", 32'(got.removed), 32'(want.removed));
          if (m_axis_tdata[TdataOutWidth-1:18] !== '0)
            report_mismatch("pad", 32'(m_axis_tdata[TdataOutWidth-1:18]), 0);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_register(input reg_index_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OWN_HIGH: own_high = value;
      REG_OWN_LOW:  own_low = value;
      default:      timeout_ms = value[31:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_requests.size() > 0 || expected_outcomes.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic request_t make_request(action_t a, logic [31:0] t, int who);
    request_t r;
    r.action = a;
    r.now_ms = t;
    r.id_high = pool_high[who];
    r.id_low = pool_low[who];
    r.lat = $urandom();
    r.lon = $urandom();
    r.speed = $urandom();
    return r;
  endfunction

  task automatic queue_request(request_t r);
    pending_requests.push_back(r);
    queued_count++;
  endtask

  // random phase: clock advances slowly so entries age within the timeout
  task automatic random_phase(int unsigned n, int unsigned step_max);
    logic [31:0] t;
    request_t r;
    int k;
    t = $urandom();
    for (int unsigned i = 0; i < n; i++) begin
      t += $urandom_range(0, step_max);
      k = $urandom_range(0, 99);
      if (k < 55) r = make_request(ACT_UPDATE, t, $urandom_range(0, 23));
      else if (k < 75) r = make_request(ACT_MARK, t, $urandom_range(0, 23));
      else if (k < 90) r = make_request(ACT_TICK, t, 0);
      else if (k < 93) r = make_request(ACT_NONE, t, 0);
      else begin
        r = make_request(action_t'($urandom_range(0, 1)), t, 0);
        r.id_high = {$urandom(), $urandom()};
        r.id_low = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) == 0) r.now_ms = $urandom();
      end
      queue_request(r);
    end
  endtask

  initial begin
    request_t r;
    own_high = '0;
    own_low = '0;
    timeout_ms = TimeoutReset;
    tbl_count = 0;
    for (int i = 0; i < 24; i++) begin
      pool_high[i] = {$urandom(), $urandom()};
      pool_low[i] = {$urandom(), $urandom()};
    end
    pool_high[1] = '1;
    pool_low[1] = '1;
    pool_high[2] = '0;
    pool_low[2] = 64'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: own id at reset (zero), extremes, full table, wrap aging
    pool_high[3] = '0;
    pool_low[3] = '0;
    queue_request(make_request(ACT_UPDATE, 32'd0, 3));
    queue_request(make_request(ACT_MARK, 32'd0, 1));
    r = make_request(ACT_UPDATE, 32'hFFFF_FFF0, 1);
    r.lat = '1; r.lon = '1; r.speed = '1;
    queue_request(r);
    r = make_request(ACT_UPDATE, 32'hFFFF_FFF8, 2);
    r.lat = '0; r.lon = '0; r.speed = '0;
    queue_request(r);
    queue_request(make_request(ACT_MARK, 32'd5, 1));
    queue_request(make_request(ACT_UPDATE, 32'd6, 1));
    for (int i = 4; i < 24; i++) queue_request(make_request(ACT_UPDATE, 32'd10, i));
    queue_request(make_request(ACT_TICK, 32'd5000, 0));
    queue_request(make_request(ACT_NONE, 32'd5000, 1));
    queue_request(make_request(ACT_TICK, 32'd5011, 0));
    queue_request(make_request(ACT_TICK, 32'hFFFF_FFFF, 0));
    wait_idle();

    // settings swept across phases, extremes included
    write_register(REG_OWN_HIGH, pool_high[5]);
    write_register(REG_OWN_LOW, pool_low[5]);
    write_register(REG_TIMEOUT, 32'd0);
    random_phase(250, 3);
    wait_idle();
    write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
    write_register(REG_OWN_HIGH, '1);
    write_register(REG_OWN_LOW, '1);
    random_phase(250, 400);
    wait_idle();
    write_register(REG_TIMEOUT, 32'd300);
    write_register(REG_OWN_HIGH, pool_high[7]);
    write_register(REG_OWN_LOW, pool_low[7]);
    random_phase(450, 40);
    wait_idle();
    write_register(REG_TIMEOUT, TimeoutReset);
    random_phase(300, 400);
    while (pending_requests.size() > 100) @(posedge clk);
    calm = 1'b1;
    random_phase(150, 400);
    wait_idle();
    send_done = 1'b1;

    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
